FILE: hdl/edt_pkg.sv
// shared types and constants for the edf deadline task queue
// used by edt_cell and edf_deadline_task_queue
package edt_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 16;
  localparam int SRC_W    = 8;
  localparam int DL_W     = 32;
  localparam int STATUS_W = 2;
  localparam int ACTIVE_W = 5;

  localparam logic OP_RELEASE  = 1'b0;
  localparam logic OP_COMPLETE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  // one slot of the sorted list
  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  id;
    logic [DL_W-1:0]  dl;
    logic [SRC_W-1:0] src;
    logic             disp;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic             en;
    logic             ins;
    logic             del;
    logic [ID_W-1:0]  id;
    logic [SRC_W-1:0] src;
    logic [DL_W-1:0]  dl;
  } cmd_t;

endpackage

FILE: hdl/edf_deadline_task_queue.sv
// earliest deadline first task queue, top level
// a row of edt_cell slots kept sorted by deadline; needs edt_pkg and edt_cell
//
// usage:
//   input channel (in_valid / in_stall) carries one item: operation 0 releases
//   a task (task_id, task_source, deadline), operation 1 completes task_id.
//   output channel (out_valid / out_stall) returns exactly one item per input
//   item: the task newly dispatched by it (if any), a status code and the
//   number of active tasks afterwards.
//   the item is registered on acceptance; then, once the output register is
//   free, every slot shifts in parallel, the head is checked for dispatch and
//   the result is registered in the output register. the block takes no new
//   item until that update is done.
//   in_stall is high while an item is in work. a result waits in the output
//   register while out_stall is high, and the next item may be accepted
//   meanwhile; its update then waits until the output register is free.
//   reset (rst, synchronous) empties the list and clears the output valid.
//   a release into a full list is dropped with status full; completion of an
//   unknown id leaves the list as is with status not found.
module edf_deadline_task_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         operation,
  input  logic [edt_pkg::ID_W-1:0]     task_id,
  input  logic [edt_pkg::SRC_W-1:0]    task_source,
  input  logic [edt_pkg::DL_W-1:0]     deadline,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         dispatch_valid,
  output logic [edt_pkg::ID_W-1:0]     dispatch_id,
  output logic [edt_pkg::SRC_W-1:0]    dispatch_source,
  output logic [edt_pkg::STATUS_W-1:0] status,
  output logic [edt_pkg::ACTIVE_W-1:0] active_count
);
  import edt_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic             state;
  logic             op_q;
  logic [ID_W-1:0]  id_q;
  logic [SRC_W-1:0] src_q;
  logic [DL_W-1:0]  dl_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic             go;
  logic             full;
  logic             busy;
  logic             mark_head;
  cmd_t             cmd;
  entry_t           cur [CAPACITY];
  entry_t           nxt [CAPACITY];
  logic [CAPACITY-1:0] ge;
  logic [CAPACITY-1:0] found;
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY-1:0] disp_vec;
  logic [STATUS_W-1:0] status_next;

  assign in_stall = (state != ST_IDLE);
  assign go       = (state == ST_EXEC) && (!out_valid || !out_stall);
  assign full     = (count == CNT_W'(CAPACITY));

  assign cmd.en  = go;
  assign cmd.ins = (op_q == OP_RELEASE) && !full;
  assign cmd.del = (op_q == OP_COMPLETE);
  assign cmd.id  = id_q;
  assign cmd.src = src_q;
  assign cmd.dl  = dl_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (in_valid) state <= ST_EXEC;
        ST_EXEC: if (go) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_q  <= operation;
      id_q  <= task_id;
      src_q <= task_source;
      dl_q  <= deadline;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   ge_prev;
    logic   found_prev;
    logic   mark_i;

    if (i == 0) begin : g_head
      assign left_e     = '0;
      assign ge_prev    = 1'b1;
      assign found_prev = 1'b0;
      assign mark_i     = mark_head;
    end else begin : g_body
      assign left_e     = cur[i-1];
      assign ge_prev    = ge[i-1];
      assign found_prev = found[i-1];
      assign mark_i     = 1'b0;
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cur[i+1];
    end

    edt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .left      (left_e),
      .right     (right_e),
      .ge_in     (ge_prev),
      .found_in  (found_prev),
      .mark      (mark_i),
      .ge_out    (ge[i]),
      .found_out (found[i]),
      .cur       (cur[i]),
      .nxt       (nxt[i])
    );

    assign valid_vec[i] = cur[i].valid;
    assign disp_vec[i]  = cur[i].disp;
  end

  always_comb begin
    count_next  = count;
    status_next = STATUS_DONE;
    if (op_q == OP_RELEASE) begin
      if (full) status_next = STATUS_FULL;
      else      count_next  = count + 1'b1;
    end else begin
      if (found[CAPACITY-1]) count_next  = count - 1'b1;
      else                   status_next = STATUS_NOT_FOUND;
    end
  end

  // dispatch check on the updated list
  always_comb begin
    busy = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      busy = busy | (nxt[i].valid & nxt[i].disp);
    end
  end

  assign mark_head = !busy && (count_next != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else if (go) begin
      count     <= count_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dispatch_valid  <= mark_head;
      dispatch_id     <= mark_head ? nxt[0].id : '0;
      dispatch_source <= mark_head ? nxt[0].src : '0;
      status          <= status_next;
      active_count    <= ACTIVE_W'(count_next);
    end
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    CNT_W'($countones(valid_vec)) == count)
    else $error("slot valid bits disagree with the task count");

  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("occupied slots are not packed at the head");

  a_one_dispatched: assert property (@(posedge clk) disable iff (rst)
    $onehot0(valid_vec & disp_vec))
    else $error("more than one task marked dispatched");

  a_dispatch_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && dispatch_valid |-> active_count != '0)
    else $error("dispatch reported with an empty list");

  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted but block not busy afterwards");

endmodule

FILE: hdl/edt_cell.sv
// one slot of the sorted task list: compares against the broadcast item
// and takes its own value, the new task, or a neighbor's slot; needs edt_pkg
module edt_cell (
  input  logic           clk,
  input  logic           rst,
  input  edt_pkg::cmd_t   cmd,
  input  edt_pkg::entry_t left,
  input  edt_pkg::entry_t right,
  input  logic           ge_in,
  input  logic           found_in,
  input  logic           mark,
  output logic           ge_out,
  output logic           found_out,
  output edt_pkg::entry_t cur,
  output edt_pkg::entry_t nxt
);
  import edt_pkg::*;

  logic match;

  // slot stays ahead of the new task when its deadline is not later
  assign ge_out    = cur.valid && (cur.dl <= cmd.dl);
  assign match     = cur.valid && (cur.id == cmd.id);
  assign found_out = found_in | match;

  always_comb begin
    nxt = cur;
    if (cmd.ins) begin
      if (!ge_out) begin
        if (ge_in) begin
          nxt.valid = 1'b1;
          nxt.id    = cmd.id;
          nxt.dl    = cmd.dl;
          nxt.src   = cmd.src;
          nxt.disp  = 1'b0;
        end else begin
          nxt = left;
        end
      end
    end else if (cmd.del) begin
      // everything from the first match onward moves one slot to the head
      if (found_out) begin
        nxt = right;
      end
    end
  end

  // only the valid and dispatched bits are reset, the payload is don't care
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
      cur.disp  <= 1'b0;
    end else if (cmd.en) begin
      cur.valid <= nxt.valid;
      cur.disp  <= nxt.disp | mark;
    end
    if (cmd.en) begin
      cur.id  <= nxt.id;
      cur.dl  <= nxt.dl;
      cur.src <= nxt.src;
    end
  end

endmodule
